// ----- src/mmcs_pkg.sv -----
// mmcs_pkg: shared types, codes and reset constants of the motion mode crossfade selector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mmcs_pkg;

	// number of special action codes; this value itself encodes "no action"
	localparam int SPECIAL_COUNT = 32;
	localparam int CODE_W = 6;
	localparam logic [CODE_W-1:0] NONE_CODE = CODE_W'(SPECIAL_COUNT);

	localparam int RATIO_FRAC_BITS_DEF = 16;

	// motion codes, also the index of each blend weight
	localparam logic [1:0] MOT_WALK    = 2'd0;
	localparam logic [1:0] MOT_SPECIAL = 2'd1;
	localparam logic [1:0] MOT_STAND   = 2'd2;

	// special action mode codes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_FIRST  = 2'd1;
	localparam logic [1:0] MODE_ACTIVE = 2'd2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W     = 16;
	localparam int CFG_CODE_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WALK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_SPECIAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_STAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_DEAD_T   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STANDUP_BACK  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STANDUP_FRONT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_DEAD_C   = 3'd6;

	localparam logic [TIME_W-1:0]     RST_BLEND_WALK    = 16'd790;
	localparam logic [TIME_W-1:0]     RST_BLEND_SPECIAL = 16'd200;
	localparam logic [TIME_W-1:0]     RST_BLEND_STAND   = 16'd600;
	localparam logic [TIME_W-1:0]     RST_PLAY_DEAD_T   = 16'd2000;
	localparam logic [CFG_CODE_W-1:0] RST_STANDUP_BACK  = 5'd0;
	localparam logic [CFG_CODE_W-1:0] RST_STANDUP_FRONT = 5'd1;
	localparam logic [CFG_CODE_W-1:0] RST_PLAY_DEAD_C   = 5'd2;

	// input request packing
	localparam int IN_BITS = 108;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [31:0]       frame_time;
		logic [1:0]        requested_motion;
		logic              contact_safe;
		logic              enforce_stand;
		logic              walk_leaving_possible;
		logic              special_leaving_possible;
		logic [CODE_W-1:0] special_action_code;
		logic [63:0]       walk_request_word;
	} in_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       div_init;
		logic       div_norm;
		logic       div_step;
		logic       upd;
		logic       norm_take;
		logic       zero_fix;
		logic       fin;
		logic [1:0] idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_run;
		logic sum_zero;
	} sts_t;

endpackage

// ----- src/motion_mode_crossfade_selector_top.sv -----
// motion_mode_crossfade_selector_top: stream wrapper joining mmcs_ctrl and mmcs_datapath
// depends on mmcs_pkg, mmcs_ctrl, mmcs_datapath
`timescale 1ns / 1ps

// one request per control frame selects walk, special action or stand as the
// motion target and crossfades three blend weights (fixed point, 1.0 equals
// 2**RATIO_FRAC_BITS) toward it by elapsed milliseconds over a blend time,
// then renormalizes them. the very first request after reset only records
// the timestamp and runs no division. the work is done by one shared
// restoring divider that yields one quotient bit per cycle and runs up to
// four times per request: once for the time step and, unless the updated
// weights add up to zero, once for each weight. a new request is taken
// only while the sequencer is idle; a finished result waits in the output
// register and the next request may be taken meanwhile. configuration
// registers (blend times and special action codes) are written through
// cfg_we/cfg_index/cfg_data and must only be written while no request is
// in flight

module motion_mode_crossfade_selector_top #(
	parameter int RATIO_FRAC_BITS = mmcs_pkg::RATIO_FRAC_BITS_DEF,
	localparam int OUT_BITS = 3 * (RATIO_FRAC_BITS + 1) + 74,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [mmcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mmcs_pkg::CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// frame_time[31:0], requested_motion[33:32], contact_safe[34], enforce_stand[35],
	// walk_leaving_possible[36], special_leaving_possible[37],
	// special_action_code[43:38], walk_request_word[107:44], zero pad
	input  logic [mmcs_pkg::IN_W-1:0]       s_tdata,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// from bit 0 up: target_motion 2, ratio_walk, ratio_special, ratio_stand
	// (RATIO_FRAC_BITS+1 each), special_mode 2, special_action_out 6,
	// walk_request_out 64, zero pad
	output logic [OUT_W-1:0]                m_tdata
);
	import mmcs_pkg::*;

	localparam int RW = RATIO_FRAC_BITS + 1;
	localparam logic [RW-1:0] ONE_R = RW'(1) << RATIO_FRAC_BITS;

	in_t  in_item;
	cmd_t cmd;
	sts_t sts;

	logic [1:0]        target_motion;
	logic [RW-1:0]     ratio_walk, ratio_special, ratio_stand;
	logic [1:0]        special_mode;
	logic [CODE_W-1:0] special_action_out;
	logic [63:0]       walk_request_out;

	// unpack the request word
	always_comb begin
		in_item.frame_time               = s_tdata[31:0];
		in_item.requested_motion         = s_tdata[33:32];
		in_item.contact_safe             = s_tdata[34];
		in_item.enforce_stand            = s_tdata[35];
		in_item.walk_leaving_possible    = s_tdata[36];
		in_item.special_leaving_possible = s_tdata[37];
		in_item.special_action_code      = s_tdata[43:38];
		in_item.walk_request_word        = s_tdata[107:44];
	end

	mmcs_ctrl #(
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mmcs_datapath #(
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_item            (in_item),
		.cmd                (cmd),
		.sts                (sts),
		.target_motion      (target_motion),
		.ratio_walk         (ratio_walk),
		.ratio_special      (ratio_special),
		.ratio_stand        (ratio_stand),
		.special_mode       (special_mode),
		.special_action_out (special_action_out),
		.walk_request_out   (walk_request_out)
	);

	// pack the result, target in the low bits
	assign m_tdata = OUT_W'({walk_request_out, special_action_out, special_mode,
	                         ratio_stand, ratio_special, ratio_walk, target_motion});

	// the sequencer takes exactly one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// normalized weights never add up past 1.0
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((RW+2)'(ratio_walk) + (RW+2)'(ratio_special) + (RW+2)'(ratio_stand))
		             <= (RW+2)'(ONE_R))
		else $error("blend weights sum above one");

	// active special mode only with full special weight
	a_active_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && special_mode == MODE_ACTIVE |-> ratio_special == ONE_R)
		else $error("special mode active without full weight");

	// walk request only passes on at full walk weight
	a_walk_gate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && walk_request_out != '0 |-> ratio_walk == ONE_R)
		else $error("walk request passed below full walk weight");

endmodule

// ----- src/mmcs_ctrl.sv -----
// mmcs_ctrl: sequencer of the crossfade selector, owns the handshakes and division step count
// depends on mmcs_pkg
`timescale 1ns / 1ps

module mmcs_ctrl #(
	parameter int RATIO_FRAC_BITS = mmcs_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  mmcs_pkg::sts_t     sts,
	output mmcs_pkg::cmd_t     cmd
);
	import mmcs_pkg::*;

	localparam int CW = $clog2(RATIO_FRAC_BITS + 1);
	localparam logic [CW-1:0] LAST_STEP = CW'(RATIO_FRAC_BITS);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PREP  = 8'b0000_0010,
		ST_DDIV  = 8'b0000_0100,
		ST_UPD   = 8'b0000_1000,
		ST_NINIT = 8'b0001_0000,
		ST_NDIV  = 8'b0010_0000,
		ST_NTAKE = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [1:0]    idx_q;
	logic          m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		cmd.idx = idx_q;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (!sts.has_run) begin
					state_d = ST_FIN;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DDIV;
				end
			end
			ST_DDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_STEP) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_NINIT;
			end
			ST_NINIT: begin
				if (sts.sum_zero) begin
					cmd.zero_fix = 1'b1;
					state_d      = ST_FIN;
				end else begin
					cmd.div_init = 1'b1;
					cmd.div_norm = 1'b1;
					state_d      = ST_NDIV;
				end
			end
			ST_NDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_STEP) state_d = ST_NTAKE;
			end
			ST_NTAKE: begin
				cmd.norm_take = 1'b1;
				state_d = (idx_q == MOT_STAND) ? ST_FIN : ST_NINIT;
			end
			ST_FIN: begin
				// wait until the output register is free
				if (!m_tvalid_q || m_tready) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + CW'(1);
			if (cmd.upd) idx_q <= '0;
			else if (cmd.norm_take) idx_q <= idx_q + 2'd1;
			if (cmd.fin) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ----- src/mmcs_datapath.sv -----
// mmcs_datapath: configuration, target selection, shared restoring divider and blend weights
// depends on mmcs_pkg; driven by mmcs_ctrl
`timescale 1ns / 1ps

module mmcs_datapath #(
	parameter int RATIO_FRAC_BITS = mmcs_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mmcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  mmcs_pkg::in_t                    in_item,
	input  mmcs_pkg::cmd_t                   cmd,
	output mmcs_pkg::sts_t                   sts,
	output logic [1:0]                       target_motion,
	output logic [RATIO_FRAC_BITS:0]         ratio_walk,
	output logic [RATIO_FRAC_BITS:0]         ratio_special,
	output logic [RATIO_FRAC_BITS:0]         ratio_stand,
	output logic [1:0]                       special_mode,
	output logic [mmcs_pkg::CODE_W-1:0]      special_action_out,
	output logic [63:0]                      walk_request_out
);
	import mmcs_pkg::*;

	localparam int F  = RATIO_FRAC_BITS;
	localparam int RW = F + 1;
	localparam int WW = F + 2;
	localparam int DW = (WW > TIME_W) ? WW : TIME_W;
	localparam logic [RW-1:0] ONE_R = RW'(1) << F;
	localparam logic [WW-1:0] ONE_W = WW'(1) << F;

	function automatic logic code_is(input logic [CODE_W-1:0] code,
	                                 input logic [CODE_W-1:0] cfg_code);
		code_is = (code < NONE_CODE) && (cfg_code < NONE_CODE) && (code == cfg_code);
	endfunction

	// configuration registers
	logic [TIME_W-1:0]     t_walk_q, t_special_q, t_stand_q, t_dead_q;
	logic [CFG_CODE_W-1:0] c_back_q, c_front_q, c_dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_walk_q    <= RST_BLEND_WALK;
			t_special_q <= RST_BLEND_SPECIAL;
			t_stand_q   <= RST_BLEND_STAND;
			t_dead_q    <= RST_PLAY_DEAD_T;
			c_back_q    <= RST_STANDUP_BACK;
			c_front_q   <= RST_STANDUP_FRONT;
			c_dead_q    <= RST_PLAY_DEAD_C;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLEND_WALK:    t_walk_q    <= cfg_data;
				CFG_BLEND_SPECIAL: t_special_q <= cfg_data;
				CFG_BLEND_STAND:   t_stand_q   <= cfg_data;
				CFG_PLAY_DEAD_T:   t_dead_q    <= cfg_data;
				CFG_STANDUP_BACK:  c_back_q    <= cfg_data[CFG_CODE_W-1:0];
				CFG_STANDUP_FRONT: c_front_q   <= cfg_data[CFG_CODE_W-1:0];
				CFG_PLAY_DEAD_C:   c_dead_q    <= cfg_data[CFG_CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// block state
	logic              has_run_q;
	logic [31:0]       last_time_q;
	logic [1:0]        target_q, last_mot_q, prev_mot_q;
	logic [CODE_W-1:0] last_special_q;
	logic [WW-1:0]     w_q [3];

	// per-request working registers
	logic [31:0]       dt_q;
	logic              sat_q;
	logic [WW-1:0]     sum_q;
	logic [CODE_W-1:0] spec_out_q;
	logic [63:0]       walk_out_q;

	// divider
	logic [DW:0]       rem_q;
	logic [DW-1:0]     den_q;
	logic [RW-1:0]     quo_q;

	// request decode
	logic [1:0]        req_in, req_g;
	logic [CODE_W-1:0] code_in;
	logic              may_change;

	always_comb begin
		req_in  = (in_item.requested_motion == 2'd3) ? MOT_STAND : in_item.requested_motion;
		code_in = (in_item.special_action_code >= NONE_CODE) ? NONE_CODE
		                                                     : in_item.special_action_code;
		req_g = req_in;
		if (req_in == MOT_WALK && (!in_item.contact_safe || in_item.enforce_stand))
			req_g = MOT_STAND;
		may_change =
			(last_mot_q == MOT_WALK &&
			 (in_item.walk_leaving_possible || !in_item.contact_safe)) ||
			(last_mot_q == MOT_STAND) ||
			(last_mot_q == MOT_SPECIAL && in_item.special_leaving_possible) ||
			(req_g == MOT_SPECIAL &&
			 (code_is(code_in, CODE_W'(c_back_q)) || code_is(code_in, CODE_W'(c_front_q))));
	end

	// blend time pick, own play dead fade time after play dead
	logic [TIME_W-1:0] t_sel;

	always_comb begin
		priority if (prev_mot_q == MOT_SPECIAL && code_is(last_special_q, CODE_W'(c_dead_q)))
			t_sel = t_dead_q;
		else if (target_q == MOT_WALK)
			t_sel = t_walk_q;
		else if (target_q == MOT_SPECIAL)
			t_sel = t_special_q;
		else
			t_sel = t_stand_q;
	end

	// one restoring step per cycle; a time step numerator above the divisor is saturated instead
	logic          div_ge;
	logic [DW:0]   div_diff, div_keep;

	assign div_ge   = rem_q >= {1'b0, den_q};
	assign div_diff = rem_q - {1'b0, den_q};
	assign div_keep = div_ge ? div_diff : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q <= '0;
			if (cmd.div_norm) begin
				rem_q <= (DW+1)'(w_q[cmd.idx]);
				den_q <= DW'(sum_q);
			end else begin
				rem_q <= (DW+1)'(dt_q[TIME_W-1:0]);
				den_q <= DW'(t_sel);
				sat_q <= dt_q >= 32'(t_sel);
			end
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[RW-2:0], div_ge};
			rem_q <= {div_keep[DW-1:0], 1'b0};
		end
	end

	// weight update toward target
	logic [RW-1:0] delta_v;
	logic [WW-1:0] w_new [3];
	logic [WW-1:0] sum_new;

	always_comb begin
		delta_v = sat_q ? ONE_R : quo_q;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) == target_q)
				w_new[i] = w_q[i] + WW'(delta_v);
			else
				w_new[i] = (w_q[i] > WW'(delta_v)) ? (w_q[i] - WW'(delta_v)) : '0;
		end
		sum_new = w_new[0] + w_new[1] + w_new[2];
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) sum_q <= sum_new;
	end

	// mode at the end of a request
	logic [1:0] mode_v;

	always_comb begin
		priority if (!has_run_q)
			mode_v = MODE_OFF;
		else if (w_q[MOT_SPECIAL] < ONE_W)
			mode_v = (target_q == MOT_SPECIAL) ? MODE_FIRST : MODE_OFF;
		else
			mode_v = MODE_ACTIVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_run_q      <= 1'b0;
			last_time_q    <= '0;
			target_q       <= MOT_STAND;
			last_mot_q     <= MOT_STAND;
			prev_mot_q     <= MOT_STAND;
			last_special_q <= NONE_CODE;
			w_q[MOT_WALK]    <= '0;
			w_q[MOT_SPECIAL] <= '0;
			w_q[MOT_STAND]   <= ONE_W;
		end else begin
			if (cmd.load) begin
				last_time_q <= in_item.frame_time;
				if (has_run_q && may_change) target_q <= req_g;
			end
			if (cmd.upd) begin
				for (int i = 0; i < 3; i++) w_q[i] <= w_new[i];
			end
			if (cmd.norm_take) w_q[cmd.idx] <= WW'(quo_q);
			if (cmd.zero_fix) begin
				for (int i = 0; i < 3; i++) w_q[i] <= (2'(i) == target_q) ? ONE_W : '0;
			end
			if (cmd.fin) begin
				has_run_q <= 1'b1;
				if (last_mot_q != target_q) prev_mot_q <= last_mot_q;
				last_mot_q <= target_q;
				if (mode_v == MODE_ACTIVE && spec_out_q != NONE_CODE)
					last_special_q <= spec_out_q;
			end
		end
	end

	// request payload and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dt_q <= in_item.frame_time - last_time_q;
			if (has_run_q) begin
				spec_out_q <= (req_g == MOT_SPECIAL) ? code_in : NONE_CODE;
				walk_out_q <= (req_g == MOT_WALK) ? in_item.walk_request_word : '0;
			end else begin
				spec_out_q <= NONE_CODE;
				walk_out_q <= '0;
			end
		end
		if (cmd.fin) begin
			target_motion      <= target_q;
			ratio_walk         <= w_q[MOT_WALK][RW-1:0];
			ratio_special      <= w_q[MOT_SPECIAL][RW-1:0];
			ratio_stand        <= w_q[MOT_STAND][RW-1:0];
			special_mode       <= mode_v;
			special_action_out <= spec_out_q;
			walk_request_out   <= (w_q[MOT_WALK] >= ONE_W) ? walk_out_q : '0;
		end
	end

	assign sts.has_run  = has_run_q;
	assign sts.sum_zero = (sum_q == '0);

endmodule
